// ===== sv/bilc_pkg.sv =====
// shared constants and types for the based integer literal converter
`timescale 1ns / 1ps

package bilc_pkg;

    // width of the converted value and of both accumulators
    localparam int VALUE_BITS = 31;
    // value field padded up to whole bytes on the output stream
    localparam int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8;
    // product plus digit: value bits, six multiplier bits, one carry bit
    localparam int PROD_W     = VALUE_BITS + 7;

    localparam int BASE_W     = 6;
    localparam int DIGIT_W    = 6;

    // characters with a meaning of their own
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;

    // digit code for a character that is no digit
    localparam logic [DIGIT_W-1:0] NO_DIGIT   = 6'd63;
    localparam logic [DIGIT_W-1:0] DEC_RADIX  = 6'd10;
    localparam logic [DIGIT_W-1:0] ALPHA_BIAS = 6'd10;

    // parse phase codes
    localparam logic [1:0] PH_DECIMAL = 2'd0;
    localparam logic [1:0] PH_BASED   = 2'd1;
    localparam logic [1:0] PH_CLOSED  = 2'd2;
    localparam logic [1:0] PH_UNUSED  = 2'd3;

    typedef logic [VALUE_BITS-1:0] t_value;

    // digit value of one character, NO_DIGIT when it is not 0-9 or A-Z
    function automatic logic [DIGIT_W-1:0] digit_of(input logic [7:0] ch);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (ch inside {[CH_ZERO:CH_NINE]}) begin
                diff = ch - CH_ZERO;
                digit_of = diff[DIGIT_W-1:0];
            end else if (ch inside {[CH_UPA:CH_UPZ]}) begin
                diff = ch - CH_UPA;
                digit_of = diff[DIGIT_W-1:0] + ALPHA_BIAS;
            end else begin
                digit_of = NO_DIGIT;
            end
        end
    endfunction

endpackage

// ===== sv/based_integer_literal_convert.sv =====
// Converts an integer literal, one character per request, into its value.
// The block takes one character every cycle unless a literal's last character
// waits for a held result register; a result passes the input register, then
// the result register. The parse state update does one multiply-add of the
// running value by the base per cycle. Underscores are skipped; plain digits
// are decimal; base#digits# with an optional closing '#' gives a based literal
// with digits 0-9 and A-Z below the base. Malformed text or a value above
// 2^31-1 sets the error flag in tuser, with the value zero.
`timescale 1ns / 1ps

module based_integer_literal_convert (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input characters
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] character
    input  logic                           i_s_tlast,   // last character
    // results
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [bilc_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [30:0] value, rest zero
    output logic [0:0]                     o_m_tuser    // [0] error
);
    import bilc_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // parse state
    logic [1:0]        r_phase, n_phase;
    logic [BASE_W-1:0] r_base,  n_base;
    t_value            r_dec,   n_dec;
    t_value            r_bsd,   n_bsd;
    logic              r_err,   n_err;

    // result register
    logic   r_out_valid;
    t_value r_out_value;
    logic   r_out_error;

    logic w_out_free;
    logic w_proc;

    logic [DIGIT_W-1:0] w_digit;
    logic [PROD_W-1:0]  w_dec_next;
    logic [PROD_W-1:0]  w_bsd_next;
    logic               w_dec_ovf;
    logic               w_bsd_ovf;
    logic               w_err_now;
    t_value             w_value;

    // handshake: the stored character moves on unless it ends a literal
    // and the result register is still held
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_proc     = r_in_valid && (!r_in_last || w_out_free);
    assign o_s_tready = !r_in_valid || w_proc;

    // one multiply-add for each accumulator
    assign w_digit    = digit_of(r_in_char);
    assign w_dec_next = PROD_W'(r_dec) * PROD_W'(DEC_RADIX) + PROD_W'(w_digit);
    assign w_bsd_next = PROD_W'(r_bsd) * PROD_W'(r_base) + PROD_W'(w_digit);
    assign w_dec_ovf  = w_dec_next > PROD_W'({VALUE_BITS{1'b1}});
    assign w_bsd_ovf  = w_bsd_next > PROD_W'({VALUE_BITS{1'b1}});

    // next parse state for the stored character
    always_comb begin
        n_phase = r_phase;
        n_base  = r_base;
        n_dec   = r_dec;
        n_bsd   = r_bsd;
        n_err   = r_err;
        if (r_in_char != CH_UNDER && !r_err) begin
            case (r_phase)
                PH_DECIMAL: begin
                    if (r_in_char == CH_HASH) begin
                        if (r_dec > t_value'({BASE_W{1'b1}})) begin
                            n_err = 1'b1;
                        end else begin
                            n_base  = r_dec[BASE_W-1:0];
                            n_phase = PH_BASED;
                        end
                    end else if (w_digit < DEC_RADIX) begin
                        if (w_dec_ovf) begin
                            n_err = 1'b1;
                        end else begin
                            n_dec = w_dec_next[VALUE_BITS-1:0];
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_BASED: begin
                    if (r_in_char == CH_HASH) begin
                        n_phase = PH_CLOSED;
                    end else if (w_digit < r_base) begin
                        if (w_bsd_ovf) begin
                            n_err = 1'b1;
                        end else begin
                            n_bsd = w_bsd_next[VALUE_BITS-1:0];
                        end
                    end else begin
                        n_err = 1'b1;
                    end
                end
                default: begin
                    // text after the closing hash
                    n_err = 1'b1;
                end
            endcase
        end
    end

    // result of a literal ending with the stored character
    assign w_err_now = n_err;
    assign w_value   = w_err_now ? '0 : ((n_phase == PH_DECIMAL) ? n_dec : n_bsd);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    // parse state, cleared after each literal
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DECIMAL;
            r_base  <= '0;
            r_dec   <= '0;
            r_bsd   <= '0;
            r_err   <= 1'b0;
        end else if (w_proc) begin
            if (r_in_last) begin
                r_phase <= PH_DECIMAL;
                r_base  <= '0;
                r_dec   <= '0;
                r_bsd   <= '0;
                r_err   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_base  <= n_base;
                r_dec   <= n_dec;
                r_bsd   <= n_bsd;
                r_err   <= n_err;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_proc && r_in_last) begin
            r_out_value <= w_value;
            r_out_error <= w_err_now;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = OUT_DATA_W'(r_out_value);
    assign o_m_tuser[0] = r_out_error;

    // an error result carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_error |-> r_out_value == '0)
        else $error("error result with nonzero value");

    // parse state is clear after a literal ends
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc && r_in_last |=> r_phase == PH_DECIMAL && !r_err && r_dec == '0)
        else $error("parse state not cleared after literal");

    // a held character stays in the input register
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_proc |=> r_in_valid && $stable(r_in_char) && $stable(r_in_last))
        else $error("stored character lost while stalled");

    // the unused phase is never entered
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_UNUSED)
        else $error("parse phase entered unused code");

endmodule
